// ===== design/prefixed_integer_parser_defines.svh =====
// Assertion macros for the prefixed integer parser.
// Included by the top level; expects clk and rst_n in scope.
`ifndef PREFIXED_INTEGER_PARSER_DEFINES_SVH
`define PREFIXED_INTEGER_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define PIP_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("pip: invariant violated");

`define PIP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pip: sequence violated");

`define PIP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pip: implication violated");

`else

`define PIP_ASSERT_ALWAYS(lbl, cond)
`define PIP_ASSERT_NEXT(lbl, ante, cons)
`define PIP_ASSERT_SAME(lbl, ante, cons)

`endif

`endif

// ===== design/pip_pkg.sv =====
// Shared types and constants for the prefixed integer parser.
// No dependencies.
package pip_pkg;

    localparam int unsigned QueueDepthDefault = 2;

    localparam logic [7:0] ChMinus = 8'h2D;  // '-'
    localparam logic [7:0] ChZero  = 8'h30;  // '0'
    localparam logic [7:0] ChNine  = 8'h39;
    localparam logic [7:0] ChSeven = 8'h37;
    localparam logic [7:0] ChUpA   = 8'h41;
    localparam logic [7:0] ChUpF   = 8'h46;
    localparam logic [7:0] ChLoA   = 8'h61;
    localparam logic [7:0] ChLoF   = 8'h66;
    localparam logic [7:0] ChLoX   = 8'h78;  // 'x'

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SIGNED = 3'd1,
        PH_ZERO   = 3'd2,
        PH_HEX    = 3'd3,
        PH_OCT    = 3'd4,
        PH_DEC    = 3'd5,
        PH_DONE   = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        BASE_OCT = 2'd0,
        BASE_DEC = 2'd1,
        BASE_HEX = 2'd2
    } base_t;

    typedef enum logic [1:0] {
        OP_NOP    = 2'd0,
        OP_DIGIT  = 2'd1,
        OP_FINISH = 2'd2
    } op_t;

    // One classified character as handed from front to back.
    typedef struct packed {
        op_t        op;
        logic       clr;    // start of a new text: accumulator counts from zero
        logic       neg;
        base_t      base;
        logic [3:0] digit;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== design/pip_if.sv =====
// Valid/ready channel interfaces for the prefixed integer parser.
// No dependencies.
interface pip_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       first;

    modport source (output valid, output ch, output first, input ready);
    modport sink   (input valid, input ch, input first, output ready);
endinterface

interface pip_value_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// ===== design/pip_front.sv =====
// Front end: accepts characters, tracks prefix/sign phase, classifies each byte.
// Depends on pip_pkg and pip_if.
module pip_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    pip_char_if.sink              chars,
    input  logic                  q_full,
    output logic                  push,
    output pip_pkg::entry_t       entry
);

    pip_pkg::phase_t phase_reg;
    pip_pkg::phase_t phase_next;
    logic            neg_reg;
    logic            neg_next;

    pip_pkg::phase_t ph;
    logic            neg_cur;
    logic            sign_start;
    pip_pkg::base_t  base_sel;
    logic            is_dig;
    logic [3:0]      dig;

    assign chars.ready = !q_full;
    assign push        = chars.valid && !q_full;

    // A first-flagged byte restarts the text in the signed phase.
    assign ph         = chars.first ? pip_pkg::PH_SIGNED : phase_reg;
    assign sign_start = chars.first && (chars.ch == pip_pkg::ChMinus);
    assign neg_cur    = chars.first ? sign_start : neg_reg;

    always_comb
    begin
        unique case (ph)
            pip_pkg::PH_ZERO, pip_pkg::PH_OCT: base_sel = pip_pkg::BASE_OCT;
            pip_pkg::PH_HEX:                   base_sel = pip_pkg::BASE_HEX;
            default:                           base_sel = pip_pkg::BASE_DEC;
        endcase
    end

    always_comb
    begin
        is_dig = 1'b0;
        dig    = 4'd0;
        priority if (chars.ch >= pip_pkg::ChZero && chars.ch <= pip_pkg::ChNine)
        begin
            dig    = 4'(chars.ch - pip_pkg::ChZero);
            is_dig = (base_sel != pip_pkg::BASE_OCT) || (chars.ch <= pip_pkg::ChSeven);
        end
        else if (chars.ch >= pip_pkg::ChUpA && chars.ch <= pip_pkg::ChUpF)
        begin
            dig    = 4'(chars.ch - pip_pkg::ChUpA + 8'd10);
            is_dig = (base_sel == pip_pkg::BASE_HEX);
        end
        else if (chars.ch >= pip_pkg::ChLoA && chars.ch <= pip_pkg::ChLoF)
        begin
            dig    = 4'(chars.ch - pip_pkg::ChLoA + 8'd10);
            is_dig = (base_sel == pip_pkg::BASE_HEX);
        end
        else
        begin
            is_dig = 1'b0;
        end
    end

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_cur;
        if (sign_start)
        begin
            phase_next = pip_pkg::PH_SIGNED;
        end
        else
        begin
            unique case (ph)
                pip_pkg::PH_SIGNED:
                    if (chars.ch == pip_pkg::ChZero)
                        phase_next = pip_pkg::PH_ZERO;
                    else
                        phase_next = is_dig ? pip_pkg::PH_DEC : pip_pkg::PH_DONE;
                pip_pkg::PH_ZERO:
                    if (chars.ch == pip_pkg::ChLoX)
                        phase_next = pip_pkg::PH_HEX;
                    else
                        phase_next = is_dig ? pip_pkg::PH_OCT : pip_pkg::PH_DONE;
                pip_pkg::PH_HEX, pip_pkg::PH_OCT, pip_pkg::PH_DEC:
                    phase_next = is_dig ? ph : pip_pkg::PH_DONE;
                default:
                    phase_next = ph;
            endcase
        end
    end

    // Outputs
    always_comb
    begin
        entry.clr   = chars.first;
        entry.neg   = neg_cur;
        entry.base  = base_sel;
        entry.digit = dig;
        entry.op    = pip_pkg::OP_NOP;
        if (!sign_start)
        begin
            unique case (ph)
                pip_pkg::PH_SIGNED:
                    if (chars.ch != pip_pkg::ChZero)
                        entry.op = is_dig ? pip_pkg::OP_DIGIT : pip_pkg::OP_FINISH;
                pip_pkg::PH_ZERO:
                    if (chars.ch != pip_pkg::ChLoX)
                        entry.op = is_dig ? pip_pkg::OP_DIGIT : pip_pkg::OP_FINISH;
                pip_pkg::PH_HEX, pip_pkg::PH_OCT, pip_pkg::PH_DEC:
                    entry.op = is_dig ? pip_pkg::OP_DIGIT : pip_pkg::OP_FINISH;
                default:
                    entry.op = pip_pkg::OP_NOP;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pip_pkg::PH_IDLE;
            neg_reg   <= 1'b0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
        end
    end

endmodule

// ===== design/pip_queue.sv =====
// Small FIFO of classified characters between front and back.
// Depends on pip_pkg.
module pip_queue
#(
    parameter int unsigned Depth = pip_pkg::QueueDepthDefault
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pip_pkg::entry_t     wr_entry,
    input  logic                pop,
    output pip_pkg::entry_t     rd_entry,
    output pip_pkg::q_status_t  status
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    pip_pkg::entry_t mem [Depth];

    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;

    assign status.full  = (count_reg == FullCnt);
    assign status.empty = (count_reg == '0);
    assign rd_entry     = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/pip_back.sv =====
// Back end: multiply-accumulate of digits and result output register.
// Depends on pip_pkg and pip_if.
module pip_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pip_pkg::entry_t       entry,
    input  logic                  q_empty,
    output logic                  pop,
    pip_value_if.source           result
);

    logic [15:0]        accum_reg;
    logic [15:0]        accum_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [15:0] out_value_reg;
    logic signed [15:0] out_value_next;

    logic [15:0] acc_base;
    logic [15:0] scaled;
    logic        is_finish;

    assign is_finish = (entry.op == pip_pkg::OP_FINISH);
    // A finishing transaction waits only while the output slot is still held.
    assign pop = !q_empty && (!is_finish || !out_valid_reg || result.ready);

    assign acc_base = entry.clr ? 16'd0 : accum_reg;

    always_comb
    begin
        unique case (entry.base)
            pip_pkg::BASE_OCT: scaled = acc_base << 3;
            pip_pkg::BASE_HEX: scaled = acc_base << 4;
            pip_pkg::BASE_DEC: scaled = (acc_base << 3) + (acc_base << 1);
            default:           scaled = (acc_base << 3) + (acc_base << 1);
        endcase
    end

    always_comb
    begin
        accum_next     = accum_reg;
        out_value_next = out_value_reg;
        out_valid_next = out_valid_reg && !result.ready;
        if (pop)
        begin
            unique case (entry.op)
                pip_pkg::OP_DIGIT:
                    accum_next = scaled + {12'd0, entry.digit};
                pip_pkg::OP_FINISH:
                begin
                    accum_next     = acc_base;
                    out_valid_next = 1'b1;
                    out_value_next = entry.neg ? signed'(16'd0 - acc_base) : signed'(acc_base);
                end
                default:
                    accum_next = acc_base;
            endcase
        end
    end

    assign result.valid = out_valid_reg;
    assign result.value = out_value_reg;

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg     <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            accum_reg     <= accum_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/prefixed_integer_parser.sv =====
// Result path: a terminating character is registered in the queue, then in the back end's
// result output register; its pop waits while the previous result is still held.
// Throughput: one character per cycle while the queue is not full.
// The character queue decouples input acceptance from a stalled result port.
// Reset (rst_n, async, active low) clears the phase, sign, accumulator, queue and result
// valid; no clearing sweep is needed. Top level: pip_front -> pip_queue -> pip_back.
`include "prefixed_integer_parser_defines.svh"

module prefixed_integer_parser
#(
    parameter int unsigned QueueDepth = pip_pkg::QueueDepthDefault
)
(
    input  logic          clk,
    input  logic          rst_n,
    pip_char_if.sink      chars,
    pip_value_if.source   result
);

    logic                q_push;
    logic                q_pop;
    pip_pkg::entry_t     wr_entry;
    pip_pkg::entry_t     rd_entry;
    pip_pkg::q_status_t  q_stat;

    pip_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars),
        .q_full (q_stat.full),
        .push   (q_push),
        .entry  (wr_entry)
    );

    pip_queue #(
        .Depth (QueueDepth)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (wr_entry),
        .pop      (q_pop),
        .rd_entry (rd_entry),
        .status   (q_stat)
    );

    pip_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .entry   (rd_entry),
        .q_empty (q_stat.empty),
        .pop     (q_pop),
        .result  (result)
    );

    `PIP_ASSERT_ALWAYS(a_queue_state, !(q_stat.full && q_stat.empty))
    `PIP_ASSERT_NEXT(a_push_fills, q_push && q_stat.empty, !q_stat.empty)
    `PIP_ASSERT_SAME(a_result_from_pop, $rose(result.valid), $past(q_pop))

endmodule
